// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometer compensation package
// Types and constants shared by the compensation pipeline and its channels.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int DT_W    = 25;
   localparam int TEMP_W  = 19;
   localparam int PRESS_W = 32;

   localparam int NUM_STAGES = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_SENS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_TEMP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TEMP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_TEMP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SLOPE      = 3'd5;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -19'sd1500;

   localparam int TEMP_SHIFT  = 23;
   localparam int T2_SHIFT    = 31;
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int PROD_SHIFT  = 21;
   localparam int PRESS_SHIFT = 15;

   typedef struct packed {
      logic [COEF_W-1:0] pressure_sens;
      logic [COEF_W-1:0] press_offset;
      logic [COEF_W-1:0] sens_temp;
      logic [COEF_W-1:0] offset_temp;
      logic [COEF_W-1:0] reference_temp;
      logic [COEF_W-1:0] temp_slope;
   } coef_set_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] stage_en;
   } pipe_ctrl_type;

endpackage

// ----- sv/bpc_if.sv -----
// ----------------------------------------------------------------------------
// Barometer compensation channels
// Valid/ready channels for conversion pairs, results and register writes.
// ----------------------------------------------------------------------------
interface bpc_req_if import bpc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] pressure_raw;
   logic [RAW_W-1:0] temperature_raw;

   modport source (output valid, output pressure_raw, output temperature_raw, input ready);
   modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [PRESS_W-1:0] pressure_pa;
   logic signed [TEMP_W-1:0]  temperature_centi;
   logic signed [DT_W-1:0]    temp_difference;

   modport source (output valid, output pressure_pa, output temperature_centi,
                   output temp_difference, input ready);
   modport sink   (input valid, input pressure_pa, input temperature_centi,
                   input temp_difference, output ready);
endinterface

interface bpc_csr_if import bpc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/baro_pressure_temp_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// Barometer pressure and temperature compensation unit
// Converts a raw pressure and temperature conversion pair into compensated
// pressure in pascals and temperature in hundredths of a degree, with the
// second-order correction applied below 20 degrees and above -15 degrees.
//
// The unit accepts one conversion pair per clock cycle unless a stall on the
// result channel has backed the pipeline up, and presents each result from
// its final stage register until the receiver takes it. The
// eight-stage pipeline depth is set by the chain of calibration products and
// the split 24 by 36 bit pressure product. A stall on the result channel
// holds the pipeline, but empty stages keep filling, so no transfer is lost
// or repeated. The six calibration words must be written while no conversion
// is in flight.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit import bpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bpc_req_if.sink    req,
   bpc_rsp_if.source  rsp,
   bpc_csr_if.sink    csr
);

   coef_set_type  coefs;
   pipe_ctrl_type ctrl;

   bpc_coef_regs u_coef_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .coefs (coefs)
   );

   bpc_stage_ctrl u_stage_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .ctrl      (ctrl)
   );

   bpc_datapath u_datapath (
      .clock           (clock),
      .ctrl            (ctrl),
      .coefs           (coefs),
      .in_pressure     (req.pressure_raw),
      .in_temperature  (req.temperature_raw),
      .out_pressure    (rsp.pressure_pa),
      .out_temperature (rsp.temperature_centi),
      .out_dt          (rsp.temp_difference)
   );

endmodule

// ----- sv/bpc_coef_regs.sv -----
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the six calibration words written over the register channel.
// ----------------------------------------------------------------------------
module bpc_coef_regs import bpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   bpc_csr_if.sink      csr,
   output coef_set_type coefs
);

   coef_set_type coefs_ff;
   coef_set_type coefs_in;

   assign csr.ready = 1'b1;
   assign coefs     = coefs_ff;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_PRESSURE_SENS:   coefs_in.pressure_sens   = csr.data;
            CSR_PRESS_OFFSET:    coefs_in.press_offset    = csr.data;
            CSR_SENS_TEMP:       coefs_in.sens_temp       = csr.data;
            CSR_OFFSET_TEMP:     coefs_in.offset_temp     = csr.data;
            CSR_REFERENCE_TEMP:  coefs_in.reference_temp  = csr.data;
            CSR_TEMP_SLOPE:      coefs_in.temp_slope      = csr.data;
            default:             coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

endmodule

// ----- sv/bpc_stage_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pipeline stage control
// Tracks a valid bit per stage and advances each stage that is empty or
// whose successor advances, so bubbles are squeezed out during a stall.
// ----------------------------------------------------------------------------
module bpc_stage_ctrl import bpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   output logic          out_valid,
   input  logic          out_ready,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready       = stage_en[0];
   assign out_valid      = valid_ff[NUM_STAGES-1];
   assign ctrl.stage_en  = stage_en;

endmodule

// ----- sv/bpc_datapath.sv -----
// ----------------------------------------------------------------------------
// Compensation datapath
// Eight register stages: temperature difference, products, first-order
// temperature with offset and sensitivity, squared deviation, second-order
// correction, split pressure product, product sum and final pressure.
// ----------------------------------------------------------------------------
module bpc_datapath import bpc_pkg::*; (
   input  logic                      clock,
   input  pipe_ctrl_type             ctrl,
   input  coef_set_type              coefs,
   input  logic [RAW_W-1:0]          in_pressure,
   input  logic [RAW_W-1:0]          in_temperature,
   output logic signed [PRESS_W-1:0] out_pressure,
   output logic signed [TEMP_W-1:0]  out_temperature,
   output logic signed [DT_W-1:0]    out_dt
);

   // Stage 0
   logic [RAW_W-1:0]       s0_d1_ff;
   logic signed [DT_W-1:0] s0_dt_ff, s0_dt_in;
   // Stage 1
   logic [RAW_W-1:0]       s1_d1_ff;
   logic signed [DT_W-1:0] s1_dt_ff;
   logic signed [41:0]     s1_dt_c6_ff, s1_dt_c6_in;
   logic signed [49:0]     s1_dt_sq_ff, s1_dt_sq_in;
   logic signed [41:0]     s1_c4_dt_ff, s1_c4_dt_in;
   logic signed [41:0]     s1_c3_dt_ff, s1_c3_dt_in;
   // Stage 2
   logic [RAW_W-1:0]         s2_d1_ff;
   logic signed [DT_W-1:0]   s2_dt_ff;
   logic signed [TEMP_W-1:0] s2_temp_ff, s2_temp_in;
   logic                     s2_corr_ff, s2_corr_in;
   logic signed [12:0]       s2_dev_ff, s2_dev_in;
   logic signed [TEMP_W-1:0] s2_t2_ff, s2_t2_in;
   logic signed [36:0]       s2_off_ff, s2_off_in;
   logic signed [35:0]       s2_sens_ff, s2_sens_in;
   // Stage 3
   logic [RAW_W-1:0]         s3_d1_ff;
   logic signed [DT_W-1:0]   s3_dt_ff;
   logic signed [TEMP_W-1:0] s3_temp_ff;
   logic signed [TEMP_W-1:0] s3_t2_ff;
   logic signed [36:0]       s3_off_ff;
   logic signed [35:0]       s3_sens_ff;
   logic [23:0]              s3_dev_sq_ff, s3_dev_sq_in;
   logic signed [25:0]       s3_dev_sq_full;
   // Stage 4
   logic [RAW_W-1:0]         s4_d1_ff;
   logic signed [DT_W-1:0]   s4_dt_ff;
   logic signed [TEMP_W-1:0] s4_temp_ff, s4_temp_in;
   logic signed [36:0]       s4_off_ff, s4_off_in;
   logic signed [35:0]       s4_sens_ff, s4_sens_in;
   logic [25:0]              s4_five_sq;
   // Stage 5
   logic signed [DT_W-1:0]   s5_dt_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   logic signed [36:0]       s5_off_ff;
   logic [41:0]              s5_pp_lo_ff, s5_pp_lo_in;
   logic signed [42:0]       s5_pp_hi_ff, s5_pp_hi_in;
   // Stage 6
   logic signed [DT_W-1:0]   s6_dt_ff;
   logic signed [TEMP_W-1:0] s6_temp_ff;
   logic signed [36:0]       s6_off_ff;
   logic signed [60:0]       s6_full;
   logic signed [39:0]       s6_prod_ff, s6_prod_in;
   // Stage 7
   logic signed [DT_W-1:0]    s7_dt_ff;
   logic signed [TEMP_W-1:0]  s7_temp_ff;
   logic signed [40:0]        s7_diff;
   logic signed [PRESS_W-1:0] s7_p_ff, s7_p_in;

   assign s0_dt_in = $signed({1'b0, in_temperature})
                   - $signed({1'b0, coefs.reference_temp, 8'b0});

   assign s1_dt_c6_in = s0_dt_ff * $signed({1'b0, coefs.temp_slope});
   assign s1_dt_sq_in = s0_dt_ff * s0_dt_ff;
   assign s1_c4_dt_in = s0_dt_ff * $signed({1'b0, coefs.offset_temp});
   assign s1_c3_dt_in = s0_dt_ff * $signed({1'b0, coefs.sens_temp});

   assign s2_temp_in = TEMP_W'(s1_dt_c6_ff >>> TEMP_SHIFT) + TEMP_BASE;
   assign s2_corr_in = (s2_temp_in < TEMP_BASE) && (s2_temp_in > TEMP_LOW);
   assign s2_dev_in  = 13'(s2_temp_in - TEMP_BASE);
   assign s2_t2_in   = s2_corr_in ? TEMP_W'(s1_dt_sq_ff >>> T2_SHIFT) : '0;
   assign s2_off_in  = $signed({5'b0, coefs.press_offset, 16'b0})
                     + 37'(s1_c4_dt_ff >>> OFF_SHIFT);
   assign s2_sens_in = $signed({5'b0, coefs.pressure_sens, 15'b0})
                     + 36'(s1_c3_dt_ff >>> SENS_SHIFT);

   assign s3_dev_sq_full = s2_dev_ff * s2_dev_ff;
   assign s3_dev_sq_in   = s2_corr_ff ? s3_dev_sq_full[23:0] : '0;

   assign s4_five_sq = {2'b0, s3_dev_sq_ff} + {s3_dev_sq_ff, 2'b0};
   assign s4_off_in  = s3_off_ff - $signed({12'b0, s4_five_sq[25:1]});
   assign s4_sens_in = s3_sens_ff - $signed({12'b0, s4_five_sq[25:2]});
   assign s4_temp_in = s3_temp_ff - s3_t2_ff;

   assign s5_pp_lo_in = s4_d1_ff * s4_sens_ff[17:0];
   assign s5_pp_hi_in = $signed({1'b0, s4_d1_ff}) * $signed(s4_sens_ff[35:18]);

   assign s6_full    = $signed({s5_pp_hi_ff, 18'b0}) + $signed({19'b0, s5_pp_lo_ff});
   assign s6_prod_in = 40'(s6_full >>> PROD_SHIFT);

   assign s7_diff = 41'(s6_prod_ff) - 41'(s6_off_ff);
   assign s7_p_in = PRESS_W'(s7_diff >>> PRESS_SHIFT);

   always_ff @(posedge clock) begin
      if (ctrl.stage_en[0]) begin
         s0_d1_ff <= in_pressure;
         s0_dt_ff <= s0_dt_in;
      end
      if (ctrl.stage_en[1]) begin
         s1_d1_ff    <= s0_d1_ff;
         s1_dt_ff    <= s0_dt_ff;
         s1_dt_c6_ff <= s1_dt_c6_in;
         s1_dt_sq_ff <= s1_dt_sq_in;
         s1_c4_dt_ff <= s1_c4_dt_in;
         s1_c3_dt_ff <= s1_c3_dt_in;
      end
      if (ctrl.stage_en[2]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_dt_ff   <= s1_dt_ff;
         s2_temp_ff <= s2_temp_in;
         s2_corr_ff <= s2_corr_in;
         s2_dev_ff  <= s2_dev_in;
         s2_t2_ff   <= s2_t2_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
      end
      if (ctrl.stage_en[3]) begin
         s3_d1_ff     <= s2_d1_ff;
         s3_dt_ff     <= s2_dt_ff;
         s3_temp_ff   <= s2_temp_ff;
         s3_t2_ff     <= s2_t2_ff;
         s3_off_ff    <= s2_off_ff;
         s3_sens_ff   <= s2_sens_ff;
         s3_dev_sq_ff <= s3_dev_sq_in;
      end
      if (ctrl.stage_en[4]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_dt_ff   <= s3_dt_ff;
         s4_temp_ff <= s4_temp_in;
         s4_off_ff  <= s4_off_in;
         s4_sens_ff <= s4_sens_in;
      end
      if (ctrl.stage_en[5]) begin
         s5_dt_ff    <= s4_dt_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_off_ff   <= s4_off_ff;
         s5_pp_lo_ff <= s5_pp_lo_in;
         s5_pp_hi_ff <= s5_pp_hi_in;
      end
      if (ctrl.stage_en[6]) begin
         s6_dt_ff   <= s5_dt_ff;
         s6_temp_ff <= s5_temp_ff;
         s6_off_ff  <= s5_off_ff;
         s6_prod_ff <= s6_prod_in;
      end
      if (ctrl.stage_en[7]) begin
         s7_dt_ff   <= s6_dt_ff;
         s7_temp_ff <= s6_temp_ff;
         s7_p_ff    <= s7_p_in;
      end
   end

   assign out_pressure    = s7_p_ff;
   assign out_temperature = s7_temp_ff;
   assign out_dt          = s7_dt_ff;

endmodule

// ----- bench/tb_baro_pressure_temp_compensation_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensation unit regression bench
// Writes calibration words, sends raw pressure and temperature conversion
// pairs and compares every compensated result with a value predicted in the
// bench. Directed tests cover reset values, unused register indexes, the
// edges of the second-order temperature band, the field extremes and one
// long output stall that backs the pipeline up to its input; random phases
// follow under varied calibration, with idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation_unit;
   import bpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic [RAW_W-1:0]     RAW_MAX       = '1;
   localparam logic [COEF_W-1:0]    COEF_MAX      = '1;

   typedef struct packed {
      logic signed [PRESS_W-1:0] pressure_pa;
      logic signed [TEMP_W-1:0]  temperature_centi;
      logic signed [DT_W-1:0]    temp_difference;
   } reading_type;

   logic clock;
   logic reset;

   bpc_req_if req_if ();
   bpc_rsp_if rsp_if ();
   bpc_csr_if csr_if ();

   baro_pressure_temp_compensation_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   coef_set_type coefs = '0;
   reading_type  expected_readings[$];
   int           fault_count     = 0;
   int           req_gap_pct     = 0;
   int           rsp_stall_pct   = 0;
   int           rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("baro_pressure_temp_compensation_unit regression: fail");
      $finish;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic reading_type compensate_reading(logic [RAW_W-1:0] d1_raw,
                                                      logic [RAW_W-1:0] d2_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, dev, t2, off2, sens2, off, sens, p, temp_out;
      reading_type res;
      d1 = {40'd0, d1_raw};
      d2 = {40'd0, d2_raw};
      c1 = {48'd0, coefs.pressure_sens};
      c2 = {48'd0, coefs.press_offset};
      c3 = {48'd0, coefs.sens_temp};
      c4 = {48'd0, coefs.offset_temp};
      c5 = {48'd0, coefs.reference_temp};
      c6 = {48'd0, coefs.temp_slope};
      dt = d2 - c5 * 256;
      temp = TEMP_BASE + ((dt * c6) >>> TEMP_SHIFT);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      if (temp < TEMP_BASE && temp > TEMP_LOW) begin
         dev = temp - TEMP_BASE;
         t2 = (dt * dt) >>> T2_SHIFT;
         off2 = 5 * dev * dev / 2;
         sens2 = 5 * dev * dev / 4;
      end
      off = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT) - off2;
      sens = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT) - sens2;
      p = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRESS_SHIFT;
      temp_out = temp - t2;
      res.pressure_pa = p[PRESS_W-1:0];
      res.temperature_centi = temp_out[TEMP_W-1:0];
      res.temp_difference = dt[DT_W-1:0];
      return res;
   endfunction

   // The receiver: a long hold-off when a test asks for one, then random stalls of varied length.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready = 1'b0;
         end else if (rsp_hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_if.ready = 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      reading_type got, want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.pressure_pa = rsp_if.pressure_pa;
         got.temperature_centi = rsp_if.temperature_centi;
         got.temp_difference = rsp_if.temp_difference;
         if (expected_readings.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: result transfer with nothing outstanding: p=%0d t=%0d dt=%0d",
                        $time, got.pressure_pa, got.temperature_centi, got.temp_difference);
         end else begin
            want = expected_readings.pop_front();
            if (got.pressure_pa !== want.pressure_pa ||
                got.temperature_centi !== want.temperature_centi ||
                got.temp_difference !== want.temp_difference) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: mismatch: expected p=%0d t=%0d dt=%0d, got p=%0d t=%0d dt=%0d",
                           $time, want.pressure_pa, want.temperature_centi,
                           want.temp_difference, got.pressure_pa,
                           got.temperature_centi, got.temp_difference);
            end
         end
      end
   end

   task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      req_if.valid = 1'b1;
      req_if.pressure_raw = d1;
      req_if.temperature_raw = d2;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_readings.push_back(compensate_reading(d1, d2));
      @(negedge clock);
      req_if.valid = 1'b0;
      if ($urandom_range(0, 99) < req_gap_pct)
         repeat (idle_length()) @(negedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_PRESSURE_SENS:   coefs.pressure_sens = value;
         CSR_PRESS_OFFSET:    coefs.press_offset = value;
         CSR_SENS_TEMP:       coefs.sens_temp = value;
         CSR_OFFSET_TEMP:     coefs.offset_temp = value;
         CSR_REFERENCE_TEMP:  coefs.reference_temp = value;
         CSR_TEMP_SLOPE:      coefs.temp_slope = value;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Calibration may only change once every conversion in flight has left.
   task automatic wait_idle();
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (NUM_STAGES + 4) @(negedge clock);
   endtask

   task automatic set_coefs(input coef_set_type cal);
      wait_idle();
      write_coef(CSR_PRESSURE_SENS, cal.pressure_sens);
      write_coef(CSR_PRESS_OFFSET, cal.press_offset);
      write_coef(CSR_SENS_TEMP, cal.sens_temp);
      write_coef(CSR_OFFSET_TEMP, cal.offset_temp);
      write_coef(CSR_REFERENCE_TEMP, cal.reference_temp);
      write_coef(CSR_TEMP_SLOPE, cal.temp_slope);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COEF_MAX;
         default: return COEF_W'($urandom_range(0, COEF_MAX));
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_pressure_raw();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return RAW_MAX;
         default: return RAW_W'($urandom_range(0, RAW_MAX));
      endcase
   endfunction

   // Most temperatures sit near the reference so that the correction band is hit often.
   function automatic logic [RAW_W-1:0] pick_temperature_raw();
      longint centre, offset, value;
      int span;
      if ($urandom_range(0, 3) == 0) return RAW_W'($urandom_range(0, RAW_MAX));
      span = $urandom_range(8, 20);
      centre = {48'd0, coefs.reference_temp} * 256;
      offset = longint'($urandom_range(0, 1 << (span + 1))) - (1 << span);
      value = centre + offset;
      if (value < 0) value = 0;
      if (value > RAW_MAX) value = RAW_MAX;
      return value[RAW_W-1:0];
   endfunction

   // With a slope word of 32768 the first-order temperature is 2000 plus dT/256.
   function automatic logic [RAW_W-1:0] raw_for_temperature(input int centi);
      longint value;
      value = {48'd0, coefs.reference_temp} * 256 + longint'(centi - 2000) * 256;
      return value[RAW_W-1:0];
   endfunction

   task automatic test_reset_coefficients();
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(24'hAAAAAA, 24'h555555);
      send_reading(24'h555555, 24'hAAAAAA);
   endtask

   task automatic test_unused_registers();
      coef_set_type cal;
      cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      set_coefs(cal);
      write_coef(CSR_UNUSED_LO, COEF_MAX);
      write_coef(CSR_UNUSED_HI, 16'h5A5A);
      send_reading(24'd9085466, 24'd8569150);
      send_reading(24'd9085466, 24'd8000000);
   endtask

   task automatic test_second_order_band();
      coef_set_type cal;
      cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd32768};
      set_coefs(cal);
      send_reading(24'd9085466, raw_for_temperature(2001));
      send_reading(24'd9085466, raw_for_temperature(2000));
      send_reading(24'd9085466, raw_for_temperature(1999));
      send_reading(24'd9085466, raw_for_temperature(500));
      send_reading(24'd9085466, raw_for_temperature(-1499));
      send_reading(24'd9085466, raw_for_temperature(-1500));
      send_reading(24'd9085466, raw_for_temperature(-1501));
      send_reading(24'd9085466, raw_for_temperature(-30000));
   endtask

   task automatic test_difference_extremes();
      coef_set_type cal;
      cal = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
      set_coefs(cal);
      send_reading(RAW_MAX, '0);
      send_reading('0, '0);
      wait_idle();
      write_coef(CSR_REFERENCE_TEMP, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, 24'd1);
   endtask

   // The receiver holds off long enough for the pipeline to fill and push back.
   task automatic test_output_stall();
      coef_set_type cal;
      cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      set_coefs(cal);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 200;
      repeat (40) send_reading(pick_pressure_raw(), pick_temperature_raw());
   endtask

   task automatic test_random_readings();
      coef_set_type cal;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: cal = '1;
            2: cal = '0;
            default: cal = '{pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                             COEF_W'($urandom_range(16'd20000, 16'd50000)), pick_coef()};
         endcase
         set_coefs(cal);
         req_gap_pct = (phase % 2 == 1) ? 30 : 0;
         rsp_stall_pct = (phase % 3 == 0) ? 0 : 25;
         if (phase == 4) begin
            req_gap_pct = 15;
            rsp_stall_pct = 15;
         end
         repeat (100) send_reading(pick_pressure_raw(), pick_temperature_raw());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pressure_raw = '0;
      req_if.temperature_raw = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_reset_coefficients();
      test_unused_registers();
      test_second_order_band();
      test_difference_extremes();
      test_output_stall();
      test_random_readings();
      wait_idle();
      if (fault_count == 0)
         $display("baro_pressure_temp_compensation_unit regression: pass");
      else
         $display("baro_pressure_temp_compensation_unit regression: fail");
      $finish;
   end

endmodule
